// ===== sv/segment_text_window_scroller_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef SEGMENT_TEXT_WINDOW_SCROLLER_UNIT_MACROS_SVH
`define SEGMENT_TEXT_WINDOW_SCROLLER_UNIT_MACROS_SVH

// Checked outside reset.
`define STWS_ASSERT(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("stws assertion failed");

// Checked during reset as well.
`define STWS_ASSERT_RST(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("stws reset assertion failed");

`endif

// ===== sv/stws_pkg.sv =====
package stws_pkg;

  localparam int DIGITS_DEF   = 4;
  localparam int TEXT_LEN_DEF = 16;
  localparam int QUEUE_DEPTH  = 2;

  typedef enum logic {
    CMD_LOAD,
    CMD_SHIFT
  } cmd_kind_t;

  // clear: blank the window before the shift; code: code shifted in
  typedef struct packed {
    cmd_kind_t  kind;
    logic       clear;
    logic [7:0] code;
  } cmd_t;

endpackage

// ===== sv/stws_front.sv =====
module stws_front #(
  parameter int DIGITS   = stws_pkg::DIGITS_DEF,
  parameter int TEXT_LEN = stws_pkg::TEXT_LEN_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [15:0]             s_tdata,  // seg_code[7:0], no_char[8], align[9]
  input  logic                    s_tuser,  // func
  input  logic                    s_tlast,  // last
  input  logic                    q_full,
  output logic                    q_push,
  output stws_pkg::cmd_t          q_cmd,
  output logic [DIGITS-1:0][7:0]  q_load
);

  localparam int IW = $clog2(TEXT_LEN);
  localparam int CW = $clog2(TEXT_LEN + 1);
  localparam int SW = $clog2(TEXT_LEN + DIGITS + 1);

  logic [TEXT_LEN-1:0][7:0] staged;
  logic [CW-1:0]            cnt;
  logic                     over;
  logic                     start;
  logic [TEXT_LEN-1:0][7:0] shown;
  logic [CW-1:0]            shown_len;
  logic                     shown_align;
  logic                     align_valid;
  logic                     scrolling;
  logic [SW-1:0]            scroll_idx;

  logic [TEXT_LEN-1:0][7:0] after;
  logic [CW-1:0]            after_cnt;
  logic                     after_over;
  logic                     same;
  logic                     fit;
  logic [SW-1:0]            offs;
  logic [SW-1:0]            src;
  logic [DIGITS-1:0][7:0]   load;
  logic                     wrap;
  logic [7:0]               tick_code;
  logic                     accept;
  logic                     is_tick;
  logic [7:0]               code;
  logic                     no_char;
  logic                     al;

  assign code     = s_tdata[7:0];
  assign no_char  = s_tdata[8];
  assign al       = s_tdata[9];
  assign is_tick  = s_tuser;
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // staging of the current character
  always_comb begin
    after      = start ? '0 : staged;
    after_cnt  = start ? '0 : cnt;
    after_over = start ? 1'b0 : over;
    if (!no_char) begin
      if (after_cnt < CW'(TEXT_LEN)) begin
        after[after_cnt[IW-1:0]] = code;
        after_cnt                = after_cnt + 1'b1;
      end else begin
        after_over = 1'b1;
      end
    end
  end

  assign same = align_valid && (shown_align == al) && (after == shown);
  assign fit  = !after_over && (SW'(after_cnt) <= SW'(DIGITS));
  assign offs = SW'(DIGITS) - SW'(after_cnt);

  // window for a text that fits
  always_comb begin
    load = '0;
    src  = '0;
    for (int p = 0; p < DIGITS; p++) begin
      if (al) begin
        src = SW'(p) - offs;
        if (SW'(p) >= offs) begin
          load[p] = after[src[IW-1:0]];
        end
      end else if (p < TEXT_LEN) begin
        load[p] = after[IW'(p)];
      end
    end
  end

  assign wrap = scroll_idx >= (SW'(shown_len) + SW'(DIGITS));

  always_comb begin
    tick_code = 8'd0;
    if (wrap) begin
      tick_code = shown[0];
    end else if (scroll_idx < SW'(shown_len)) begin
      tick_code = shown[scroll_idx[IW-1:0]];
    end
  end

  always_comb begin
    q_push = 1'b0;
    q_cmd  = '{kind: stws_pkg::CMD_SHIFT, clear: 1'b0, code: 8'd0};
    q_load = load;
    if (accept) begin
      if (is_tick) begin
        q_push = scrolling;
        q_cmd  = '{kind: stws_pkg::CMD_SHIFT, clear: wrap, code: tick_code};
      end else if (s_tlast && !same) begin
        q_push = 1'b1;
        if (fit) begin
          q_cmd = '{kind: stws_pkg::CMD_LOAD, clear: 1'b0, code: 8'd0};
        end else begin
          q_cmd = '{kind: stws_pkg::CMD_SHIFT, clear: 1'b1, code: after[0]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start       <= 1'b1;
      cnt         <= '0;
      over        <= 1'b0;
      shown       <= '0;
      shown_len   <= '0;
      shown_align <= 1'b0;
      align_valid <= 1'b0;
      scrolling   <= 1'b0;
      scroll_idx  <= '0;
    end else if (accept) begin
      if (is_tick) begin
        if (scrolling) begin
          scroll_idx <= wrap ? SW'(1) : scroll_idx + 1'b1;
        end
      end else begin
        staged <= after;
        cnt    <= after_cnt;
        over   <= after_over;
        start  <= s_tlast;
        if (s_tlast && !same) begin
          shown       <= after;
          shown_len   <= after_cnt;
          shown_align <= al;
          align_valid <= 1'b1;
          scrolling   <= !fit;
          scroll_idx  <= SW'(1);
        end
      end
    end
  end

endmodule

// ===== sv/stws_queue.sv =====
module stws_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = stws_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [NW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == NW'(DEPTH));
  assign valid   = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/stws_back.sv =====
module stws_back #(
  parameter int DIGITS = stws_pkg::DIGITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  stws_pkg::cmd_t         q_cmd,
  input  logic [DIGITS-1:0][7:0] q_load,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [15:0]            m_tdata,  // digit[1:0], segments[9:2]
  output logic                   m_tlast   // frame_end
);

  localparam int DW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  logic [DIGITS-1:0][7:0] window;
  logic [DIGITS-1:0][7:0] window_next;
  logic [DIGITS-1:0][7:0] base;
  logic                   busy;
  logic [DW-1:0]          idx;
  logic                   load;
  logic                   at_last;
  logic [1:0]             digit;
  logic [7:0]             segments;

  assign load    = busy && (!m_tvalid || m_tready);
  assign at_last = (idx == DW'(DIGITS - 1));
  assign q_pop   = q_valid && (!busy || (load && at_last));
  assign m_tdata = {6'd0, segments, digit};

  always_comb begin
    base        = q_cmd.clear ? '0 : window;
    window_next = base;
    case (q_cmd.kind)
      stws_pkg::CMD_LOAD: begin
        window_next = q_load;
      end
      stws_pkg::CMD_SHIFT: begin
        for (int j = 0; j < DIGITS - 1; j++) begin
          window_next[j] = base[j+1];
        end
        window_next[DIGITS-1] = q_cmd.code;
      end
      default: window_next = window;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digit    <= 2'(idx);
      segments <= window[idx];
      m_tlast  <= at_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window   <= '0;
      busy     <= 1'b0;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (q_pop) begin
        window <= window_next;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (q_pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (load) begin
        if (at_last) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

endmodule

// ===== sv/segment_text_window_scroller_unit.sv =====
// A word that ends a changed text, or a tick during a marquee, passes the command
// queue, the window register and the output registers before its first digit word
// is on m_*; a frame is DIGITS words. Throughput: one input word per cycle while the
// two-entry queue has room; frames go out one word per cycle while m_tready is high.
// Reset (rst, synchronous): shown text cleared, no alignment shown, marquee off,
// window blank, queue and output empty.
module segment_text_window_scroller_unit #(
  parameter int DIGITS   = stws_pkg::DIGITS_DEF,
  parameter int TEXT_LEN = stws_pkg::TEXT_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // seg_code[7:0], no_char[8], align[9]
  input  logic        s_tuser,   // func
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // digit[1:0], segments[9:2]
  output logic        m_tlast    // frame_end
);

  localparam int QW = DIGITS * 8 + $bits(stws_pkg::cmd_t);

  logic                   f_push;
  stws_pkg::cmd_t         f_cmd;
  logic [DIGITS-1:0][7:0] f_load;
  logic                   q_full;
  logic                   q_valid;
  logic                   q_pop;
  logic [QW-1:0]          q_rdata;
  stws_pkg::cmd_t         b_cmd;
  logic [DIGITS-1:0][7:0] b_load;

  assign {b_load, b_cmd} = q_rdata;

  stws_front #(
    .DIGITS   (DIGITS),
    .TEXT_LEN (TEXT_LEN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (f_push),
    .q_cmd    (f_cmd),
    .q_load   (f_load)
  );

  stws_queue #(
    .WIDTH (QW),
    .DEPTH (stws_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata ({f_load, f_cmd}),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  stws_back #(
    .DIGITS (DIGITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (b_cmd),
    .q_load   (b_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== sv/stws_checker.sv =====
`include "segment_text_window_scroller_unit_macros.svh"

module stws_checker #(
  parameter int DIGITS = stws_pkg::DIGITS_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  `STWS_ASSERT_RST(a_rst_out_empty, clk, rst |=> !m_tvalid)
  `STWS_ASSERT_RST(a_rst_ready, clk, rst |=> s_tready)
  `STWS_ASSERT(a_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
  `STWS_ASSERT(a_end_digit, clk, rst, m_tvalid && m_tlast |-> m_tdata[1:0] == 2'(DIGITS - 1))
  `STWS_ASSERT(a_pad_zero, clk, rst, m_tvalid |-> m_tdata[15:10] == 6'd0)

endmodule

bind segment_text_window_scroller_unit stws_checker #(.DIGITS(DIGITS)) u_stws_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== bench/segment_text_window_scroller_unit_tb.sv =====
`timescale 1ns / 100ps

module segment_text_window_scroller_unit_tb;

  localparam int DIGITS      = stws_pkg::DIGITS_DEF;
  localparam int TEXT_LEN    = stws_pkg::TEXT_LEN_DEF;
  localparam int RANDOM_WORDS = 140;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 100000;
  localparam int MAX_REPORTS = 10;

  localparam logic FUNC_CHAR   = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;
  localparam logic ALIGN_LEFT  = 1'b0;
  localparam logic ALIGN_RIGHT = 1'b1;
  localparam int   ALIGN_NONE  = 2;

  typedef struct {
    logic [1:0] digit;
    logic [7:0] segs;
    logic       fend;
  } digit_word_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // seg_code[7:0], no_char[8], align[9]
  logic        s_tuser;   // func
  logic        s_tlast;   // last
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // digit[1:0], segments[9:2]
  logic        m_tlast;   // frame_end

  segment_text_window_scroller_unit #(
    .DIGITS  (DIGITS),
    .TEXT_LEN(TEXT_LEN)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  // scroller model state
  logic [7:0]  stage_buf [TEXT_LEN];
  int unsigned stage_cnt;
  bit          stage_over;
  bit          new_text;
  logic [7:0]  shown_buf [TEXT_LEN];
  int unsigned shown_len;
  int unsigned shown_al;
  logic [7:0]  win [DIGITS];
  int unsigned scroll_pos;
  bit          marquee_on;

  digit_word_t pending_digits[$];

  bit          idle_on;
  int          hold_left;
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned words_sent, ticks_sent, texts_sent, ignored_ticks;
  int unsigned digits_checked, wrap_count, overlong_count, unchanged_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void push_frame();
    digit_word_t w;
    for (int d = 0; d < DIGITS; d++) begin
      w.digit = 2'(d);
      w.segs  = win[d];
      w.fend  = (d == DIGITS - 1);
      pending_digits.push_back(w);
    end
  endfunction

  function automatic void shift_window();
    logic [7:0] c;
    c = 8'h00;
    if (scroll_pos >= shown_len + DIGITS) begin
      for (int j = 0; j < DIGITS; j++) win[j] = 8'h00;
      scroll_pos = 0;
      wrap_count++;
    end
    for (int j = 0; j < DIGITS - 1; j++) win[j] = win[j + 1];
    if (scroll_pos < shown_len && scroll_pos < TEXT_LEN) c = shown_buf[scroll_pos];
    win[DIGITS - 1] = c;
    scroll_pos++;
    push_frame();
  endfunction

  function automatic void predict_word(logic func, logic [7:0] code, logic no_char,
                                       logic is_last, logic align);
    bit same;
    int unsigned pos;
    if (func == FUNC_TICK) begin
      if (marquee_on) shift_window();
      else ignored_ticks++;
      return;
    end
    if (new_text) begin
      for (int i = 0; i < TEXT_LEN; i++) stage_buf[i] = 8'h00;
      stage_cnt  = 0;
      stage_over = 1'b0;
      new_text   = 1'b0;
    end
    if (!no_char) begin
      if (stage_cnt < TEXT_LEN) begin
        stage_buf[stage_cnt] = code;
        stage_cnt++;
      end else begin
        stage_over = 1'b1;
      end
    end
    if (!is_last) return;
    new_text = 1'b1;
    same = (int'(align) == shown_al);
    for (int i = 0; i < TEXT_LEN; i++)
      if (stage_buf[i] != shown_buf[i]) same = 1'b0;
    if (same) begin
      unchanged_count++;
      return;
    end
    shown_buf = stage_buf;
    shown_len = stage_cnt;
    shown_al  = int'(align);
    for (int j = 0; j < DIGITS; j++) win[j] = 8'h00;
    if (!stage_over && stage_cnt <= DIGITS) begin
      for (int i = 0; i < stage_cnt; i++) begin
        pos = (align == ALIGN_RIGHT) ? i + DIGITS - stage_cnt : i;
        win[pos] = shown_buf[i];
      end
      marquee_on = 1'b0;
      push_frame();
    end else begin
      if (stage_over) overlong_count++;
      scroll_pos = 0;
      marquee_on = 1'b1;
      shift_window();
    end
  endfunction

  // entered and left at a rising edge; s_tvalid stays high between words unless idle_on adds a gap
  task automatic send_word(input logic func, input logic [7:0] code, input logic no_char,
                           input logic is_last, input logic align);
    if (idle_on && $urandom_range(0, 99) < 13) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tlast  <= is_last;
    s_tdata  <= {6'b0, align, no_char, code};
    do @(posedge clk); while (!s_tready);
    predict_word(func, code, no_char, is_last, align);
    words_sent++;
    if (func == FUNC_TICK) ticks_sent++;
  endtask

  task automatic send_text(input logic [7:0] codes[$], input logic align, input int blank_pct);
    if (codes.size() == 0) begin
      send_word(FUNC_CHAR, 8'($urandom), 1'b1, 1'b1, align);
    end else begin
      for (int i = 0; i < codes.size(); i++) begin
        if ($urandom_range(0, 99) < blank_pct)
          send_word(FUNC_CHAR, 8'($urandom), 1'b1, 1'b0, 1'($urandom));
        send_word(FUNC_CHAR, codes[i], 1'b0, i == codes.size() - 1,
                  (i == codes.size() - 1) ? align : 1'($urandom));
      end
    end
    texts_sent++;
  endtask

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++)
      send_word(FUNC_TICK, 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // receiver side; hold_left forces a long hold-off
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (idle_on) begin
        m_tready <= ($urandom_range(0, 99) >= 13);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_output
    digit_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      digits_checked++;
      if (pending_digits.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected word: digit %0d segments %02h frame_end %0b",
                   m_tdata[1:0], m_tdata[9:2], m_tlast);
      end else begin
        want = pending_digits.pop_front();
        if (m_tdata[1:0] !== want.digit || m_tdata[9:2] !== want.segs ||
            m_tlast !== want.fend) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display({"mismatch: digit exp %0d got %0d, segments exp %02h got %02h, ",
                      "frame_end exp %0b got %0b"},
                     want.digit, m_tdata[1:0], want.segs, m_tdata[9:2], want.fend, m_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still pending", cycle_count,
               pending_digits.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_tick_while_idle();
    send_ticks(1);
  endtask

  task automatic test_short_texts();
    logic [7:0] codes[$];
    codes = {};
    send_text(codes, ALIGN_LEFT, 0);    // empty text, alignment differs from reset
    send_text(codes, ALIGN_LEFT, 0);    // unchanged, no frame
    codes = {8'hFF};
    send_text(codes, ALIGN_RIGHT, 0);
    codes = {8'h00, 8'hFF, 8'hA5, 8'h5A};
    send_text(codes, ALIGN_LEFT, 0);
    codes = {8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h00};  // trailing zero code: equal
    send_text(codes, ALIGN_LEFT, 0);
    codes = {8'h00, 8'hFF, 8'hA5, 8'h5A};
    send_text(codes, ALIGN_RIGHT, 0);
    send_word(FUNC_CHAR, 8'h81, 1'b0, 1'b0, ALIGN_LEFT);
    send_word(FUNC_CHAR, 8'hFF, 1'b1, 1'b0, ALIGN_RIGHT);  // no-char inside text
    send_word(FUNC_CHAR, 8'h7E, 1'b0, 1'b0, ALIGN_RIGHT);
    send_word(FUNC_CHAR, 8'h00, 1'b1, 1'b1, ALIGN_RIGHT);  // no-char that ends it
    texts_sent++;
    send_ticks(1);
  endtask

  task automatic test_overlong_marquee();
    logic [7:0] codes[$];
    codes = {};
    for (int i = 0; i < TEXT_LEN + 1; i++) codes.push_back(8'(8'h10 + i));
    send_text(codes, ALIGN_RIGHT, 0);
    send_ticks(2);
  endtask

  task automatic test_receiver_holdoff();
    logic [7:0] codes[$];
    codes = {};
    for (int i = 0; i < DIGITS + 2; i++) codes.push_back(8'($urandom_range(1, 255)));
    idle_on = 1'b0;
    send_text(codes, ALIGN_LEFT, 0);
    hold_left = HOLD_CYCLES;
    send_ticks(12);
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [7:0] codes[$];
    int unsigned base, sent, len, r;
    logic al;
    base = words_sent - ignored_ticks;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      idle_on = !(sent >= 50 && sent < 100);
      r = $urandom_range(0, 99);
      codes = {};
      if (r < 70) begin
        if ($urandom_range(0, 5) == 0 && shown_al != ALIGN_NONE) begin
          for (int i = 0; i < shown_len; i++) codes.push_back(shown_buf[i]);
          len = $urandom_range(0, TEXT_LEN - shown_len);
          for (int i = 0; i < len; i++) codes.push_back(8'h00);
          al = shown_al[0];
        end else begin
          len = ($urandom_range(0, 3) != 0) ? $urandom_range(0, DIGITS + 1)
                                             : $urandom_range(DIGITS + 2, TEXT_LEN + 4);
          for (int i = 0; i < len; i++) codes.push_back(8'($urandom));
          al = 1'($urandom);
        end
        send_text(codes, al, 10);
        if (marquee_on) send_ticks($urandom_range(0, shown_len + DIGITS + 3));
      end else if (r < 85) begin
        send_word(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        // unfinished text with ticks mixed in
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++)
          send_word(FUNC_CHAR, 8'($urandom), 1'b0, 1'b0, 1'($urandom));
        send_ticks($urandom_range(1, 3));
      end
      sent = words_sent - ignored_ticks - base;
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    s_tlast  = 1'b0;
    idle_on  = 1'b1;
    hold_left = 0;
    cycle_count = 0;
    error_count = 0;
    words_sent = 0;
    ticks_sent = 0;
    texts_sent = 0;
    ignored_ticks = 0;
    digits_checked = 0;
    wrap_count = 0;
    overlong_count = 0;
    unchanged_count = 0;
    for (int i = 0; i < TEXT_LEN; i++) begin
      stage_buf[i] = 8'h00;
      shown_buf[i] = 8'h00;
    end
    for (int j = 0; j < DIGITS; j++) win[j] = 8'h00;
    stage_cnt  = 0;
    stage_over = 1'b0;
    new_text   = 1'b1;
    shown_len  = 0;
    shown_al   = ALIGN_NONE;
    scroll_pos = 0;
    marquee_on = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_tick_while_idle();
    test_short_texts();
    test_overlong_marquee();
    test_receiver_holdoff();
    test_random_traffic();

    s_tvalid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words: %0d texts, %0d scroll ticks (%0d while idle); %0d digit words",
             words_sent, texts_sent, ticks_sent, ignored_ticks, digits_checked);
    $display("Marquee wraps %0d, over-long texts %0d, unchanged texts %0d, errors %0d",
             wrap_count, overlong_count, unchanged_count, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/stws_pkg.sv
sv/stws_front.sv
sv/stws_queue.sv
sv/stws_back.sv
sv/segment_text_window_scroller_unit.sv
sv/stws_checker.sv
bench/segment_text_window_scroller_unit_tb.sv
